>>> rtl/ufsf_pkg.sv
// Shared types and constants of the union-find spanning forest core.
package ufsf_pkg;

    localparam int VERT_W = 12;
    localparam int CNT_W  = 13;
    localparam int RANK_W = 4;
    localparam int TOT_W  = 12;

    localparam logic [RANK_W-1:0] RANK_MAX    = 4'd15;
    localparam logic [TOT_W-1:0]  TOTAL_MAX   = 12'd4095;
    localparam logic [CNT_W-1:0]  COUNT_RESET = 13'd4096;

    localparam logic OP_EDGE  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic              op;
        logic [VERT_W-1:0] vertex_a;
        logic [VERT_W-1:0] vertex_b;
        logic              bad;
    } item_t;

    typedef struct packed {
        logic [VERT_W-1:0] end_a;
        logic [VERT_W-1:0] end_b;
        logic              joined;
        logic              bad_vertex;
        logic [TOT_W-1:0]  tree_edges;
    } result_t;

endpackage

>>> rtl/union_find_spanning_forest_core.sv
// Top level of the union-find spanning forest core: ports, config, result register.
//
//  channel | ports                                     | dir | word
//  --------+-------------------------------------------+-----+-----------------------------
//  s_      | s_valid s_ready s_operation s_vertex_a/b  | in  | edge offer or forest clear
//  m_      | m_valid m_ready m_end_a/b m_joined        | out | one result per input word
//          | m_bad_vertex m_tree_edges                 |     |
//  cfg_    | cfg_valid cfg_ready cfg_wdata             | in  | vertex_count register write
//
//  An edge walks both endpoints to their roots (path reads, then compression
//  writes along the path) and then does up to two link writes; every read uses
//  the single read port of the forest memory.
//  A bad edge reads no memory. A clear sweeps every entry, one entry a cycle.
//  After reset the same sweep runs before s_ready rises.
//  A finished result waits in the output register; the next word is taken meanwhile,
//  and the core holds in its final step only while that register is still full.
module union_find_spanning_forest_core #(
    parameter int MAX_VERTICES = 4096
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_operation,
    input  logic [ufsf_pkg::VERT_W-1:0]   s_vertex_a,
    input  logic [ufsf_pkg::VERT_W-1:0]   s_vertex_b,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ufsf_pkg::VERT_W-1:0]   m_end_a,
    output logic [ufsf_pkg::VERT_W-1:0]   m_end_b,
    output logic                          m_joined,
    output logic                          m_bad_vertex,
    output logic [ufsf_pkg::TOT_W-1:0]    m_tree_edges,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ufsf_pkg::CNT_W-1:0]    cfg_wdata
);
    import ufsf_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int DW = AW + RANK_W;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0]      limit;
    item_t            item;
    logic             seq_ready;
    logic             res_valid, res_ready, res_load;
    result_t          res;
    logic             m_valid_reg, m_valid_next;
    result_t          out_reg, out_next;

    logic             rd_en, wr_en;
    logic [AW-1:0]    rd_addr, wr_addr;
    logic [DW-1:0]    rd_data, wr_data;

    // configuration: always ready; the user must write it only while idle, the block does not enforce this
    assign cfg_ready  = 1'b1;
    assign count_next = cfg_valid ? cfg_wdata : count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= COUNT_RESET;
        end else begin
            count_reg <= count_next;
        end
    end

    // clamp the vertex count to the memory depth; zero flags every edge
    assign limit = (32'(count_reg) > 32'(MAX_VERTICES)) ? 32'(MAX_VERTICES)
                                                        : 32'(count_reg);

    always_comb begin
        item          = '0;
        item.op       = s_operation;
        item.vertex_a = s_vertex_a;
        item.vertex_b = s_vertex_b;
        item.bad      = (32'(s_vertex_a) >= limit) || (32'(s_vertex_b) >= limit);
    end

    assign s_ready = seq_ready;

    ufsf_seq #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_valid),
        .item      (item),
        .ready     (seq_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    ufsf_ram #(
        .DEPTH (MAX_VERTICES),
        .AW    (AW),
        .DW    (DW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // output register: load when empty or draining this cycle, else hold
    assign res_ready    = !m_valid_reg || m_ready;
    assign res_load     = res_valid && res_ready;
    assign m_valid_next = res_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    assign out_next     = res_load ? res : out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_end_a      = out_reg.end_a;
    assign m_end_b      = out_reg.end_b;
    assign m_joined     = out_reg.joined;
    assign m_bad_vertex = out_reg.bad_vertex;
    assign m_tree_edges = out_reg.tree_edges;

endmodule

>>> rtl/ufsf_ram.sv
// Forest memory: one write port, one registered read port with write forwarding.
module ufsf_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 16
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // forward a same-cycle write so the reader sees the newest word
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
            end else begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/ufsf_seq.sv
// Sequencer: clear sweep, root walks, path compression and union by rank.
module ufsf_seq #(
    parameter int  MAX_VERTICES = 4096,
    localparam int AW = $clog2(MAX_VERTICES),
    localparam int DW = AW + ufsf_pkg::RANK_W
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  ufsf_pkg::item_t   item,
    output logic              ready,
    output logic              res_valid,
    input  logic              res_ready,
    output ufsf_pkg::result_t res,
    output logic              rd_en,
    output logic [AW-1:0]     rd_addr,
    input  logic [DW-1:0]     rd_data,
    output logic              wr_en,
    output logic [AW-1:0]     wr_addr,
    output logic [DW-1:0]     wr_data
);
    import ufsf_pkg::*;

    localparam logic [AW-1:0] LAST = AW'(MAX_VERTICES - 1);

    typedef enum logic [6:0] {
        ST_SWEEP = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_FIND  = 7'b0000100,
        ST_FIX   = 7'b0001000,
        ST_LINK  = 7'b0010000,
        ST_BUMP  = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [AW-1:0]       sweep_reg, sweep_next;
    logic                pend_reg, pend_next;
    logic                side_reg, side_next;
    logic [TOT_W-1:0]    total_reg, total_next;
    logic [AW-1:0]       cur_reg, cur_next;
    logic [AW-1:0]       root_reg, root_next;
    logic [AW-1:0]       root_a_reg, root_a_next;
    logic [AW-1:0]       root_b_reg, root_b_next;
    logic [RANK_W-1:0]   rank_a_reg, rank_a_next;
    logic [RANK_W-1:0]   rank_b_reg, rank_b_next;
    logic [VERT_W-1:0]   a_reg, a_next;
    logic [VERT_W-1:0]   b_reg, b_next;
    logic                op_reg, op_next;
    logic                bad_reg, bad_next;
    logic                joined_reg, joined_next;

    logic [AW-1:0]       rd_par;
    logic [RANK_W-1:0]   rd_rank;
    logic [AW-1:0]       va, vb, start_v;
    logic                swap;
    logic [AW-1:0]       hi_root, lo_root;
    logic [RANK_W-1:0]   hi_rank, lo_rank;
    logic                fin;
    logic [AW-1:0]       fin_root;

    assign rd_par  = rd_data[AW-1:0];
    assign rd_rank = rd_data[DW-1:AW];
    assign va      = AW'(a_reg);
    assign vb      = AW'(b_reg);
    assign start_v = side_reg ? vb : va;

    // lower rank goes under the higher; on a tie the root of vertex_a stays
    assign swap    = (rank_a_reg < rank_b_reg);
    assign hi_root = swap ? root_b_reg : root_a_reg;
    assign lo_root = swap ? root_a_reg : root_b_reg;
    assign hi_rank = swap ? rank_b_reg : rank_a_reg;
    assign lo_rank = swap ? rank_a_reg : rank_b_reg;

    always_comb begin
        state_next  = state_reg;
        sweep_next  = sweep_reg;
        pend_next   = pend_reg;
        side_next   = side_reg;
        total_next  = total_reg;
        cur_next    = cur_reg;
        root_next   = root_reg;
        root_a_next = root_a_reg;
        root_b_next = root_b_reg;
        rank_a_next = rank_a_reg;
        rank_b_next = rank_b_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        op_next     = op_reg;
        bad_next    = bad_reg;
        joined_next = joined_reg;
        rd_en       = 1'b0;
        rd_addr     = cur_reg;
        wr_en       = 1'b0;
        wr_addr     = cur_reg;
        wr_data     = '0;
        fin         = 1'b0;
        fin_root    = cur_reg;

        case (state_reg)
            ST_SWEEP: begin
                wr_en      = 1'b1;
                wr_addr    = sweep_reg;
                wr_data    = {RANK_W'(0), sweep_reg};
                sweep_next = sweep_reg + AW'(1);
                if (sweep_reg == LAST) begin
                    sweep_next = '0;
                    pend_next  = 1'b0;
                    state_next = pend_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    a_next      = item.vertex_a;
                    b_next      = item.vertex_b;
                    op_next     = item.op;
                    bad_next    = 1'b0;
                    joined_next = 1'b0;
                    side_next   = 1'b0;
                    if (item.op == OP_CLEAR) begin
                        total_next = '0;
                        pend_next  = 1'b1;
                        state_next = ST_SWEEP;
                    end else if (item.bad) begin
                        bad_next   = 1'b1;
                        state_next = ST_DONE;
                    end else begin
                        cur_next   = AW'(item.vertex_a);
                        rd_en      = 1'b1;
                        rd_addr    = AW'(item.vertex_a);
                        state_next = ST_FIND;
                    end
                end
            end
            ST_FIND: begin
                if (rd_par == cur_reg) begin
                    if (side_reg) begin
                        rank_b_next = rd_rank;
                    end else begin
                        rank_a_next = rd_rank;
                    end
                    if (start_v == cur_reg) begin
                        fin      = 1'b1;
                        fin_root = cur_reg;
                    end else begin
                        root_next  = cur_reg;
                        cur_next   = start_v;
                        rd_en      = 1'b1;
                        rd_addr    = start_v;
                        state_next = ST_FIX;
                    end
                end else begin
                    cur_next = rd_par;
                    rd_en    = 1'b1;
                    rd_addr  = rd_par;
                end
            end
            ST_FIX: begin
                wr_en   = 1'b1;
                wr_addr = cur_reg;
                wr_data = {rd_rank, root_reg};
                if (rd_par == root_reg) begin
                    fin      = 1'b1;
                    fin_root = root_reg;
                end else begin
                    cur_next = rd_par;
                    rd_en    = 1'b1;
                    rd_addr  = rd_par;
                end
            end
            ST_LINK: begin
                wr_en       = 1'b1;
                wr_addr     = lo_root;
                wr_data     = {lo_rank, hi_root};
                joined_next = 1'b1;
                if (total_reg != TOTAL_MAX) begin
                    total_next = total_reg + TOT_W'(1);
                end
                if ((lo_rank == hi_rank) && (hi_rank != RANK_MAX)) begin
                    state_next = ST_BUMP;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_BUMP: begin
                wr_en      = 1'b1;
                wr_addr    = hi_root;
                wr_data    = {hi_rank + RANK_W'(1), hi_root};
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // root of one endpoint settled: start on vertex_b or decide the link
        if (fin) begin
            if (!side_reg) begin
                root_a_next = fin_root;
                side_next   = 1'b1;
                cur_next    = vb;
                rd_en       = 1'b1;
                rd_addr     = vb;
                state_next  = ST_FIND;
            end else begin
                root_b_next = fin_root;
                state_next  = (fin_root == root_a_reg) ? ST_DONE : ST_LINK;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_SWEEP;
            sweep_reg <= '0;
            pend_reg  <= 1'b0;
            side_reg  <= 1'b0;
            total_reg <= '0;
        end else begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            pend_reg  <= pend_next;
            side_reg  <= side_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg    <= cur_next;
        root_reg   <= root_next;
        root_a_reg <= root_a_next;
        root_b_reg <= root_b_next;
        rank_a_reg <= rank_a_next;
        rank_b_reg <= rank_b_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        op_reg     <= op_next;
        bad_reg    <= bad_next;
        joined_reg <= joined_next;
    end

    assign ready     = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);

    always_comb begin
        res            = '0;
        res.end_a      = (op_reg == OP_CLEAR) ? '0 : a_reg;
        res.end_b      = (op_reg == OP_CLEAR) ? '0 : b_reg;
        res.joined     = joined_reg;
        res.bad_vertex = bad_reg;
        res.tree_edges = total_reg;
    end

    a_bump_after_link: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BUMP) |-> ($past(state_reg) == ST_LINK))
        else $error("rank bump without a preceding link");

    a_fix_not_root: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIX) |-> (cur_reg != root_reg))
        else $error("path compression rewrote the root");

    a_result_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> !(res.joined && res.bad_vertex))
        else $error("result both joined and bad");

    a_total_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg != ST_SWEEP) && !(start && ready && (item.op == OP_CLEAR)))
        |=> (total_reg >= $past(total_reg)))
        else $error("tree edge count fell without a clear");

endmodule
